// ===== rtl/core/mtcsr_pkg.sv =====
// Package for the machine-mode trap and CSR unit.
// Holds item, result and CSR state types plus encodings and cause codes.
// No dependencies.
`default_nettype none

package mtcsr_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned IN_TDATA_W = 136;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [31:0] W_ECALL = 32'h0000_0073;
  localparam logic [31:0] W_EBREAK = 32'h0010_0073;
  localparam logic [31:0] W_MRET = 32'h3020_0073;

  localparam logic [11:0] CSR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_MTVEC = 12'h305;
  localparam logic [11:0] CSR_MSCRATCH = 12'h340;
  localparam logic [11:0] CSR_MEPC = 12'h341;
  localparam logic [11:0] CSR_MCAUSE = 12'h342;
  localparam logic [11:0] CSR_MTVAL = 12'h343;

  localparam logic [2:0] F3_PRIV = 3'd0;
  localparam logic [2:0] F3_CSRRW = 3'd1;
  localparam logic [2:0] F3_CSRRS = 3'd2;
  localparam logic [2:0] F3_CSRRC = 3'd3;
  localparam logic [2:0] F3_RSVD = 3'd4;
  localparam logic [2:0] F3_CSRRWI = 3'd5;
  localparam logic [2:0] F3_CSRRSI = 3'd6;
  localparam logic [2:0] F3_CSRRCI = 3'd7;

  localparam logic [31:0] CAUSE_ILLEGAL = 32'd2;
  localparam logic [31:0] CAUSE_BREAK = 32'd3;
  localparam logic [31:0] CAUSE_ECALL_M = 32'd11;

  localparam int unsigned ST_MIE_BIT = 3;
  localparam int unsigned ST_MPIE_BIT = 7;
  localparam logic [31:0] ST_MPP = 32'h0000_1800;

  typedef struct packed {
    logic        cmd;
    logic [31:0] instr;
    logic [31:0] rs1_value;
    logic [31:0] pc;
    logic [4:0]  fault_cause;
    logic [31:0] fault_value;
  } item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        rd_write;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic        trap_taken;
    logic        double_fault;
  } result_t;

  typedef struct packed {
    logic [31:0] mstatus;
    logic [31:0] mtvec;
    logic [31:0] mscratch;
    logic [31:0] mepc;
    logic [31:0] mcause;
    logic [31:0] mtval;
  } csr_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtcsr_exec.sv =====
// Combinational execute step of the trap and CSR unit.
// Decodes one item against the current CSR state, forms the result and next state.
// Depends on mtcsr_pkg.
`default_nettype none

module mtcsr_exec (
  input  mtcsr_pkg::item_t      item,
  input  mtcsr_pkg::csr_state_t state,
  output mtcsr_pkg::result_t    res,
  output mtcsr_pkg::csr_state_t state_nxt
);

  logic [2:0]  f3;
  logic [11:0] csr_addr;
  logic [4:0]  rs1f;
  logic        op_ok;
  logic        csr_hit;
  logic        is_ecall;
  logic        is_ebreak;
  logic        is_mret;
  logic        is_trap;
  logic [31:0] cause;
  logic [31:0] tval;
  logic [31:0] vec;
  logic        dbl;
  logic [31:0] old;
  logic [31:0] nv;
  logic        wr;
  logic [31:0] uimm;
  logic [31:0] st_trap;
  logic [31:0] st_mret;

  assign f3 = item.instr[14:12];
  assign csr_addr = item.instr[31:20];
  assign rs1f = item.instr[19:15];
  assign uimm = {27'd0, rs1f};
  assign op_ok = item.instr[6:0] == mtcsr_pkg::OP_SYSTEM;
  assign is_ecall = item.instr == mtcsr_pkg::W_ECALL;
  assign is_ebreak = item.instr == mtcsr_pkg::W_EBREAK;
  assign is_mret = !item.cmd && item.instr == mtcsr_pkg::W_MRET;
  assign vec = {state.mtvec[31:2], 2'b00};
  assign dbl = vec == item.pc;

  always_comb begin
    csr_hit = 1'b1;
    case (csr_addr)
      mtcsr_pkg::CSR_MSTATUS:  old = state.mstatus;
      mtcsr_pkg::CSR_MTVEC:    old = state.mtvec;
      mtcsr_pkg::CSR_MSCRATCH: old = state.mscratch;
      mtcsr_pkg::CSR_MEPC:     old = state.mepc;
      mtcsr_pkg::CSR_MCAUSE:   old = state.mcause;
      mtcsr_pkg::CSR_MTVAL:    old = state.mtval;
      default: begin
        old = '0;
        csr_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (f3)
      mtcsr_pkg::F3_CSRRW: begin
        wr = 1'b1;
        nv = item.rs1_value;
      end
      mtcsr_pkg::F3_CSRRS: begin
        wr = rs1f != 5'd0;
        nv = old | item.rs1_value;
      end
      mtcsr_pkg::F3_CSRRC: begin
        wr = rs1f != 5'd0;
        nv = old & ~item.rs1_value;
      end
      mtcsr_pkg::F3_CSRRWI: begin
        wr = 1'b1;
        nv = uimm;
      end
      mtcsr_pkg::F3_CSRRSI: begin
        wr = rs1f != 5'd0;
        nv = old | uimm;
      end
      mtcsr_pkg::F3_CSRRCI: begin
        wr = rs1f != 5'd0;
        nv = old & ~uimm;
      end
      default: begin
        wr = 1'b0;
        nv = old;
      end
    endcase
  end

  always_comb begin
    is_trap = item.cmd || !op_ok
           || (f3 == mtcsr_pkg::F3_PRIV && !is_mret)
           || (f3 != mtcsr_pkg::F3_PRIV && (!csr_hit || f3 == mtcsr_pkg::F3_RSVD));
    if (item.cmd) begin
      cause = {27'd0, item.fault_cause};
      tval = item.fault_value;
    end else if (op_ok && is_ecall) begin
      cause = mtcsr_pkg::CAUSE_ECALL_M;
      tval = '0;
    end else if (op_ok && is_ebreak) begin
      cause = mtcsr_pkg::CAUSE_BREAK;
      tval = item.pc;
    end else begin
      cause = mtcsr_pkg::CAUSE_ILLEGAL;
      tval = item.instr;
    end
  end

  always_comb begin
    st_trap = state.mstatus | mtcsr_pkg::ST_MPP;
    st_trap[mtcsr_pkg::ST_MPIE_BIT] = state.mstatus[mtcsr_pkg::ST_MIE_BIT];
    st_trap[mtcsr_pkg::ST_MIE_BIT] = 1'b0;
    st_mret = state.mstatus | mtcsr_pkg::ST_MPP;
    st_mret[mtcsr_pkg::ST_MIE_BIT] = state.mstatus[mtcsr_pkg::ST_MPIE_BIT];
    st_mret[mtcsr_pkg::ST_MPIE_BIT] = 1'b1;
  end

  always_comb begin
    state_nxt = state;
    res = '0;
    if (is_trap) begin
      if (dbl) begin
        res.next_pc = item.pc;
        res.double_fault = 1'b1;
      end else begin
        res.next_pc = vec;
        res.trap_taken = 1'b1;
        state_nxt.mepc = item.pc;
        state_nxt.mcause = cause;
        state_nxt.mtval = tval;
        state_nxt.mstatus = st_trap;
      end
    end else if (is_mret) begin
      res.next_pc = state.mepc;
      state_nxt.mstatus = st_mret;
    end else begin
      res.next_pc = item.pc + 32'd4;
      res.rd_write = 1'b1;
      res.rd_index = item.instr[11:7];
      res.rd_value = old;
      if (wr) begin
        case (csr_addr)
          mtcsr_pkg::CSR_MSTATUS:  state_nxt.mstatus = nv;
          mtcsr_pkg::CSR_MTVEC:    state_nxt.mtvec = nv;
          mtcsr_pkg::CSR_MSCRATCH: state_nxt.mscratch = nv;
          mtcsr_pkg::CSR_MEPC:     state_nxt.mepc = nv;
          mtcsr_pkg::CSR_MCAUSE:   state_nxt.mcause = nv;
          mtcsr_pkg::CSR_MTVAL:    state_nxt.mtval = nv;
          default: state_nxt = state;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/machine_trap_csr_unit.sv =====
// Top level of the machine-mode trap and CSR unit of an RV32 core.
// Depends on mtcsr_pkg and mtcsr_exec.
//
// Usage:
//   in_*  : one item per transfer. in_tuser is cmd (0 = SYSTEM instruction,
//           1 = fault from elsewhere); in_tdata carries the instruction,
//           rs1 value, pc, fault cause and fault value.
//   out_* : one result per item, in order: next pc, rd write/index/value,
//           trap taken and double fault flags.
//   From input transfer to result transfer, an item is held in the input
//   register, then decode and CSR update load the result register, which
//   raises out_tvalid. The unit takes one item per cycle while out_tready
//   stays high; the CSR file is written as an item moves from the input
//   register into the result register, so the next item sees the updated
//   CSRs.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_tready drops until out_tready returns.
//   Reset clears all six CSRs and both valid flags.
`default_nettype none

module machine_trap_csr_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [31:0] instr, [63:32] rs1_value, [95:64] pc, [100:96] fault_cause,
  // [132:101] fault_value, [135:133] zero
  input  wire logic [mtcsr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] cmd
  input  wire logic                                 in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [31:0] next_pc, [32] rd_write, [37:33] rd_index, [69:38] rd_value,
  // [70] trap_taken, [71] double_fault
  output logic [mtcsr_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  logic                  s0_valid_r;
  mtcsr_pkg::item_t      s0_item_r;
  logic                  out_valid_r;
  mtcsr_pkg::result_t    out_res_r;
  mtcsr_pkg::csr_state_t csr_r;
  mtcsr_pkg::csr_state_t csr_nxt;
  mtcsr_pkg::result_t    res;
  mtcsr_pkg::item_t      in_item;
  logic                  advance;

  assign in_item.cmd = in_tuser;
  assign in_item.instr = in_tdata[31:0];
  assign in_item.rs1_value = in_tdata[63:32];
  assign in_item.pc = in_tdata[95:64];
  assign in_item.fault_cause = in_tdata[100:96];
  assign in_item.fault_value = in_tdata[132:101];

  assign advance = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || advance;

  mtcsr_exec u_exec (
    .item      (s0_item_r),
    .state     (csr_r),
    .res       (res),
    .state_nxt (csr_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csr_r <= '0;
    end else if (advance) begin
      csr_r <= csr_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_res_r.double_fault, out_res_r.trap_taken, out_res_r.rd_value,
                      out_res_r.rd_index, out_res_r.rd_write, out_res_r.next_pc};

  a_trap_excl: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !(res.trap_taken && (res.double_fault || res.rd_write)))
    else $error("trap result also marks double fault or rd write");

  a_trap_mie: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.trap_taken) |=> !csr_r.mstatus[mtcsr_pkg::ST_MIE_BIT])
    else $error("MIE still set after trap entry");

  a_dbl_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.double_fault) |=> $stable(csr_r))
    else $error("CSR state changed on double fault");

  a_no_out_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !s0_valid_r) |=> !out_valid_r)
    else $error("result appeared without an item");

endmodule

`default_nettype wire
